@@ hw/rtl/occupancy_input_qualifier_top_assert.svh @@
// Assertion macros for the occupancy qualifier top.
`ifndef OCCUPANCY_INPUT_QUALIFIER_TOP_ASSERT_SVH
`define OCCUPANCY_INPUT_QUALIFIER_TOP_ASSERT_SVH

// same-cycle implication
`define OIQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/oiq_pkg.sv @@
// ---------------------------------------------------------------------------
// oiq_pkg
// Shared constants, types and helpers for the occupancy input qualifier.
// ---------------------------------------------------------------------------
package oiq_pkg;

  localparam int NUM_PORTS_DEF = 32;

  localparam logic [5:0]  USED_PORTS_RST    = 6'd32;
  localparam logic [15:0] RELEASE_DELAY_RST = 16'd1500;
  localparam logic [9:0]  BLINK_WRAP        = 10'd500;
  localparam logic [9:0]  BLINK_HALF        = 10'd250;
  localparam logic [15:0] CNT_MAX           = 16'hFFFF;

  localparam logic [2:0] CFG_USED_PORTS    = 3'd0;
  localparam logic [2:0] CFG_SENSE_MODE    = 3'd1;
  localparam logic [2:0] CFG_BUS_IDENT     = 3'd2;
  localparam logic [2:0] CFG_FIRST_ADDRESS = 3'd3;
  localparam logic [2:0] CFG_RELEASE_DELAY = 3'd4;

  localparam logic [2:0] SENSE_NONE  = 3'd0;
  localparam logic [2:0] SENSE_ONE   = 3'd1;
  localparam logic [2:0] SENSE_TWO   = 3'd2;
  localparam logic [2:0] SENSE_FOUR  = 3'd3;
  localparam logic [2:0] SENSE_EIGHT = 3'd4;

  typedef struct packed {
    logic        l_next;
    logic        run_next;
    logic        event_hit;
    logic        power;
    logic [15:0] cnt_next;
  } lane_out_t;

  // port that senses power for port p
  function automatic logic [4:0] sense_index(input logic [2:0] mode, input logic [4:0] p);
    logic [4:0] r;
    r = 5'd0;
    case (mode)
      SENSE_ONE:   r = 5'd0;
      SENSE_TWO:   r = {p[4], 4'd0};
      SENSE_FOUR:  r = {p[4:3], 3'd0};
      default:     r = p[2] ? {p[4:2], 2'b11} : {p[4:2], 2'b00};
    endcase
    return r;
  endfunction

  function automatic logic is_sense(input logic [2:0] mode, input logic [4:0] p);
    logic r;
    r = 1'b0;
    case (mode)
      SENSE_ONE:   r = (p == 5'd0);
      SENSE_TWO:   r = (p[3:0] == 4'd0);
      SENSE_FOUR:  r = (p[2:0] == 3'd0);
      SENSE_EIGHT: r = (p[2:0] == 3'd0) || (p[2:0] == 3'd7);
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/occupancy_input_qualifier_top.sv @@
// ---------------------------------------------------------------------------
// occupancy_input_qualifier_top
// Occupancy qualifier for active-low track inputs with per-port lanes.
// Latency: first result of a scan is valid the cycle after it is accepted.
// Throughput: events of a scan leave one per cycle while out_ready is high.
// A new scan is taken in the cycle its predecessor's last result is taken.
// Reset (rst, synchronous) restores register defaults and clears lane, LED, blink and handshake state.
// ---------------------------------------------------------------------------
module occupancy_input_qualifier_top #(
  parameter int NUM_PORTS = oiq_pkg::NUM_PORTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] track_bits,
  input  logic        tick_elapsed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        event_valid,
  output logic [31:0] contact_number,
  output logic        was_occupied,
  output logic        now_occupied,
  output logic [31:0] led_pattern,
  output logic        last_result
);
  `include "occupancy_input_qualifier_top_assert.svh"

  localparam logic [31:0] PM = 32'((64'd1 << NUM_PORTS) - 64'd1);

  logic [5:0]  used_ports;
  logic [2:0]  sense_mode;
  logic [15:0] bus_ident, first_address, release_delay;

  logic [31:0] logic_bits, timer_running, led_bits;
  logic [15:0] release_count [NUM_PORTS];
  logic [8:0]  blink_count;
  logic        blink_phase;

  logic        busy;
  logic [31:0] pend_mask, pend_was, pend_now, pend_led, pend_base;

  logic [31:0] raw;
  logic [9:0]  bc1;
  logic [8:0]  blink_count_next;
  logic        blink_phase_next;
  logic [31:0] logic_next, run_next, ev_vec, was_vec, now_vec, used_vec, power_vec;
  logic [31:0] led_next;
  logic [15:0] cnt_next [NUM_PORTS];
  logic        in_fire, out_fire;
  logic [4:0]  idx;
  logic [31:0] remaining;

  assign raw = track_bits | ~PM;

  always_comb begin
    bc1 = {1'b0, blink_count} + {9'd0, tick_elapsed};
    blink_phase_next = blink_phase;
    blink_count_next = bc1[8:0];
    if (bc1 >= oiq_pkg::BLINK_WRAP) begin
      blink_phase_next = 1'b0;
      blink_count_next = '0;
    end else if (bc1 >= oiq_pkg::BLINK_HALF) begin
      blink_phase_next = 1'b1;
    end
  end

  for (genvar p = 0; p < 32; p++) begin : g_lane
    if (p < NUM_PORTS) begin : g_act
      oiq_pkg::lane_out_t lo;
      oiq_lane #(.PORT(p)) u_lane (
        .raw(raw), .tick(tick_elapsed), .sense_mode(sense_mode),
        .used_ports(used_ports), .release_delay(release_delay),
        .l(logic_bits[p]), .run(timer_running[p]), .cnt(release_count[p]), .lo(lo)
      );
      assign logic_next[p] = lo.l_next;
      assign run_next[p]   = lo.run_next;
      assign ev_vec[p]     = lo.event_hit;
      assign power_vec[p]  = lo.power;
      assign cnt_next[p]   = lo.cnt_next;
      assign used_vec[p]   = 6'(p) < used_ports;
    end else begin : g_off
      assign logic_next[p] = 1'b1;
      assign run_next[p]   = 1'b0;
      assign ev_vec[p]     = 1'b0;
      assign power_vec[p]  = 1'b1;
      assign used_vec[p]   = 1'b0;
    end
    assign was_vec[p] = !logic_bits[p];
    assign now_vec[p] = !raw[p];
  end

  oiq_led_merge u_merge (
    .led_old(led_bits), .logic_old(logic_bits), .logic_new(logic_next),
    .used(used_vec), .power(power_vec), .phase(blink_phase_next), .led_new(led_next)
  );

  // output side: lowest pending event first
  always_comb begin
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (pend_mask[i]) idx = 5'(i);
    end
  end
  assign remaining      = pend_mask & (pend_mask - 32'd1);
  assign out_valid      = busy;
  assign event_valid    = pend_mask != '0;
  assign last_result    = remaining == '0;
  assign contact_number = event_valid ? pend_base + {27'd0, idx} : '0;
  assign was_occupied   = event_valid && pend_was[idx];
  assign now_occupied   = event_valid && pend_now[idx];
  assign led_pattern    = pend_led;
  assign in_ready       = !busy || (out_ready && last_result);
  assign in_fire        = in_valid && in_ready;
  assign out_fire       = busy && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_ports    <= oiq_pkg::USED_PORTS_RST;
      sense_mode    <= oiq_pkg::SENSE_NONE;
      bus_ident     <= '0;
      first_address <= '0;
      release_delay <= oiq_pkg::RELEASE_DELAY_RST;
      logic_bits    <= '1;
      timer_running <= '0;
      led_bits      <= '0;
      blink_count   <= '0;
      blink_phase   <= 1'b0;
      busy          <= 1'b0;
      pend_mask     <= '0;
      for (int i = 0; i < NUM_PORTS; i++) release_count[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          oiq_pkg::CFG_USED_PORTS:    used_ports    <= cfg_data[5:0];
          oiq_pkg::CFG_SENSE_MODE:    sense_mode    <= cfg_data[2:0];
          oiq_pkg::CFG_BUS_IDENT:     bus_ident     <= cfg_data;
          oiq_pkg::CFG_FIRST_ADDRESS: first_address <= cfg_data;
          oiq_pkg::CFG_RELEASE_DELAY: release_delay <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        logic_bits    <= logic_next;
        timer_running <= run_next;
        led_bits      <= led_next;
        blink_count   <= blink_count_next;
        blink_phase   <= blink_phase_next;
        for (int i = 0; i < NUM_PORTS; i++) release_count[i] <= cnt_next[i];
        busy      <= 1'b1;
        pend_mask <= ev_vec;
        pend_was  <= was_vec;
        pend_now  <= now_vec;
        pend_led  <= ~led_next & PM;
        pend_base <= {bus_ident, 16'd0} + {16'd0, first_address};
      end else if (out_fire) begin
        if (last_result) busy <= 1'b0;
        pend_mask <= remaining;
      end
    end
  end

  `OIQ_ASSERT_NOW(a_noevt_alone, out_valid && !event_valid, last_result, "empty result not last")
  `OIQ_ASSERT_NEXT(a_fire_valid, in_fire, out_valid, "accepted scan gave no result")
  `OIQ_ASSERT_NOW(a_ready_drain, busy && in_ready, out_ready && last_result,
                  "scan taken while results pending")
endmodule

@@ hw/rtl/oiq_lane.sv @@
// ---------------------------------------------------------------------------
// oiq_lane
// Per-port occupancy/release qualifier: decides the next logic bit, timer
// state, release count and event flag of one port for one scan.
// ---------------------------------------------------------------------------
module oiq_lane #(
  parameter int PORT = 0
) (
  input  logic [31:0]      raw,
  input  logic             tick,
  input  logic [2:0]       sense_mode,
  input  logic [5:0]       used_ports,
  input  logic [15:0]      release_delay,
  input  logic             l,
  input  logic             run,
  input  logic [15:0]      cnt,
  output oiq_pkg::lane_out_t lo
);
  localparam logic [4:0] P = 5'(PORT);

  logic        a, used, m, power;
  logic [15:0] cnt1;

  always_comb begin
    a    = raw[P];
    used = {1'b0, P} < used_ports;
    m    = oiq_pkg::is_sense(sense_mode, P);
    if (sense_mode >= oiq_pkg::SENSE_ONE && sense_mode <= oiq_pkg::SENSE_EIGHT) begin
      power = !raw[oiq_pkg::sense_index(sense_mode, P)];
    end else begin
      power = 1'b1;
    end
    cnt1 = (tick && run && cnt != oiq_pkg::CNT_MAX) ? cnt + 16'd1 : cnt;

    lo.l_next    = l;
    lo.run_next  = run;
    lo.cnt_next  = cnt1;
    lo.event_hit = 1'b0;
    lo.power     = power;
    if (!a && l && used) begin
      lo.l_next    = 1'b0;
      lo.event_hit = 1'b1;
    end else if (!a) begin
      lo.run_next = 1'b0;
      lo.cnt_next = '0;
    end else if (!l && (cnt1 >= release_delay || m)) begin
      lo.l_next    = 1'b1;
      lo.event_hit = 1'b1;
      lo.run_next  = 1'b0;
      lo.cnt_next  = '0;
    end else if (!l && cnt1 == '0 && (power || m)) begin
      lo.run_next = 1'b1;
    end else if (!power && cnt1 != '0) begin
      lo.run_next = 1'b0;
      lo.cnt_next = '0;
    end
  end
endmodule

@@ hw/rtl/oiq_led_merge.sv @@
// ---------------------------------------------------------------------------
// oiq_led_merge
// Merges lane results into the LED word; each byte walks its eight ports in
// order since the byte compare sees earlier ports' updates.
// ---------------------------------------------------------------------------
module oiq_led_merge (
  input  logic [31:0] led_old,
  input  logic [31:0] logic_old,
  input  logic [31:0] logic_new,
  input  logic [31:0] used,
  input  logic [31:0] power,
  input  logic        phase,
  output logic [31:0] led_new
);
  always_comb begin
    logic [7:0] lb, gb;
    led_new = led_old;
    for (int b = 0; b < 4; b++) begin
      lb = led_old[b*8 +: 8];
      gb = logic_old[b*8 +: 8];
      for (int j = 0; j < 8; j++) begin
        gb[j] = logic_new[b*8 + j];
        if (!power[b*8 + j] && used[b*8 + j]) begin
          lb[j] = !(!logic_old[b*8 + j] && phase);
        end else if (used[b*8 + j] && lb != gb) begin
          lb[j] = logic_old[b*8 + j];
        end else if (!used[b*8 + j]) begin
          lb[j] = 1'b0;
        end
      end
      led_new[b*8 +: 8] = lb;
    end
  end
endmodule

@@ tb/occupancy_input_qualifier_top_tb.sv @@
// ---------------------------------------------------------------------------
// occupancy_input_qualifier_top_tb
// Drives track scans with random timing on both handshakes, predicts every
// port event and the LED pattern per scan, and compares each result
// transaction in order against the predicted queue.
// ---------------------------------------------------------------------------
module occupancy_input_qualifier_top_tb;

  typedef struct packed {
    logic        event_valid;
    logic [31:0] contact_number;
    logic        was_occupied;
    logic        now_occupied;
    logic [31:0] led_pattern;
    logic        last_result;
  } port_event_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] track_bits;
  logic        tick_elapsed;
  logic        out_valid;
  logic        out_ready;
  logic        event_valid;
  logic [31:0] contact_number;
  logic        was_occupied;
  logic        now_occupied;
  logic [31:0] led_pattern;
  logic        last_result;

  occupancy_input_qualifier_top i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .track_bits(track_bits),
    .tick_elapsed(tick_elapsed), .out_valid(out_valid), .out_ready(out_ready),
    .event_valid(event_valid), .contact_number(contact_number),
    .was_occupied(was_occupied), .now_occupied(now_occupied),
    .led_pattern(led_pattern), .last_result(last_result)
  );

  // predictor state
  logic [5:0]  cur_used;
  logic [2:0]  cur_sense;
  logic [15:0] cur_bus;
  logic [15:0] cur_first;
  logic [15:0] cur_delay;
  logic [31:0] occ_logic;
  logic [31:0] timer_on;
  logic [15:0] release_cnt [32];
  logic [31:0] led_dark;
  int unsigned blink_cnt;
  logic        blink_on;

  port_event_t expected_events[$];
  int          error_count;
  int          cycle_count;
  int          hold_cycles;
  bit          wide_gaps;
  logic [31:0] occ_mask;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 900000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [4:0] power_port(input logic [4:0] grp);
    case (cur_sense)
      oiq_pkg::SENSE_ONE:  return 5'd0;
      oiq_pkg::SENSE_TWO:  return 5'((grp >> 2) * 16);
      oiq_pkg::SENSE_FOUR: return 5'((grp >> 1) * 8);
      default:             return grp[0] ? 5'(4 * grp + 3) : 5'(4 * grp);
    endcase
  endfunction

  function automatic logic senses_power(input int p);
    case (cur_sense)
      oiq_pkg::SENSE_ONE:   return p == 0;
      oiq_pkg::SENSE_TWO:   return p == 0 || p == 16;
      oiq_pkg::SENSE_FOUR:  return (p & 7) == 0;
      oiq_pkg::SENSE_EIGHT: return (p & 7) == 0 || (p & 7) == 7;
      default:              return 1'b0;
    endcase
  endfunction

  task automatic predict_scan(input logic [31:0] raw, input logic tick);
    port_event_t ev;
    port_event_t scan_events[$];
    logic a, l, used, sp, power, hit;
    int sh;
    if (tick && blink_cnt < 511) blink_cnt++;
    if (blink_cnt >= 500) begin
      blink_on = 1'b0;
      blink_cnt = 0;
    end else if (blink_cnt >= 250) begin
      blink_on = 1'b1;
    end
    if (tick)
      for (int p = 0; p < 32; p++)
        if (timer_on[p] && release_cnt[p] != 16'hFFFF) release_cnt[p]++;
    for (int p = 0; p < 32; p++) begin
      a = raw[p];
      l = occ_logic[p];
      used = p < cur_used;
      sp = senses_power(p);
      power = 1'b1;
      hit = 1'b0;
      sh = (p >> 3) * 8;
      if (cur_sense >= oiq_pkg::SENSE_ONE && cur_sense <= oiq_pkg::SENSE_EIGHT)
        power = raw[power_port(5'(p >> 2))] == 1'b0;
      if (a < l && used) begin
        occ_logic[p] = 1'b0;
        hit = 1'b1;
      end else if (a == 1'b0) begin
        timer_on[p] = 1'b0;
        release_cnt[p] = '0;
      end else if (l < a && (release_cnt[p] >= cur_delay || sp)) begin
        occ_logic[p] = 1'b1;
        hit = 1'b1;
        timer_on[p] = 1'b0;
        release_cnt[p] = '0;
      end else if (l < a && release_cnt[p] == 0 && (power || sp)) begin
        timer_on[p] = 1'b1;
      end else if (!power && release_cnt[p] > 0) begin
        timer_on[p] = 1'b0;
        release_cnt[p] = '0;
      end
      if (hit) begin
        ev = '0;
        ev.event_valid = 1'b1;
        ev.contact_number = ({16'd0, cur_bus} << 16) + {16'd0, cur_first} + 32'(p);
        ev.was_occupied = ~l;
        ev.now_occupied = ~a;
        scan_events.push_back(ev);
      end
      if (!power && used)
        led_dark[p] = (l == 1'b0 && blink_on) ? 1'b0 : 1'b1;
      else if (used && led_dark[sh +: 8] != occ_logic[sh +: 8])
        led_dark[p] = l;
      else if (!used)
        led_dark[p] = 1'b0;
    end
    if (scan_events.size() == 0) scan_events.push_back('0);
    foreach (scan_events[k]) begin
      scan_events[k].led_pattern = ~led_dark;
      scan_events[k].last_result = (k == scan_events.size() - 1);
      expected_events.push_back(scan_events[k]);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    port_event_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch("unexpected result", contact_number, 32'd0);
      end else begin
        want = expected_events.pop_front();
        if (event_valid !== want.event_valid)
          report_mismatch("event_valid", 32'(event_valid), 32'(want.event_valid));
        if (contact_number !== want.contact_number)
          report_mismatch("contact_number", contact_number, want.contact_number);
        if (was_occupied !== want.was_occupied)
          report_mismatch("was_occupied", 32'(was_occupied), 32'(want.was_occupied));
        if (now_occupied !== want.now_occupied)
          report_mismatch("now_occupied", 32'(now_occupied), 32'(want.now_occupied));
        if (led_pattern !== want.led_pattern)
          report_mismatch("led_pattern", led_pattern, want.led_pattern);
        if (last_result !== want.last_result)
          report_mismatch("last_result", 32'(last_result), 32'(want.last_result));
      end
    end
  end

  function automatic int gap_len();
    if (!wide_gaps) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3);
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int n;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      n = gap_len();
      out_ready = (n == 0);
      if (n > 0) repeat (n) @(negedge clk);
      out_ready = 1'b1;
      @(negedge clk);
    end
  end

  task automatic send_scan(input logic [31:0] raw, input logic tick);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid = 1'b1;
    track_bits = raw;
    tick_elapsed = tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_scan(raw, tick);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (expected_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      oiq_pkg::CFG_USED_PORTS:    cur_used = val[5:0];
      oiq_pkg::CFG_SENSE_MODE:    cur_sense = val[2:0];
      oiq_pkg::CFG_BUS_IDENT:     cur_bus = val;
      oiq_pkg::CFG_FIRST_ADDRESS: cur_first = val;
      oiq_pkg::CFG_RELEASE_DELAY: cur_delay = val;
      default: ;
    endcase
    if (cur_used > 32) cur_used = 32;
  endtask

  // occupied ports draw current: clear bits of a random subset
  function automatic logic [31:0] occupancy_word();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return ~(32'd1 << $urandom_range(0, 31));
      2: return occ_mask;
      default: return occ_mask ^ (32'd1 << $urandom_range(0, 31));
    endcase
  endfunction

  task automatic test_directed();
    wide_gaps = 0;
    send_scan(32'hFFFF_FFFF, 1'b0);
    send_scan(32'h0000_0000, 1'b1);
    send_scan(32'h0000_0000, 1'b0);
    send_scan(32'hFFFF_FFFF, 1'b1);
    drain();
    write_reg(oiq_pkg::CFG_RELEASE_DELAY, 16'd0);
    write_reg(oiq_pkg::CFG_BUS_IDENT, 16'hFFFF);
    write_reg(oiq_pkg::CFG_FIRST_ADDRESS, 16'hFFFF);
    send_scan(32'h5555_AAAA, 1'b1);
    send_scan(32'hFFFF_FFFF, 1'b1);
    send_scan(32'hFFFF_FFFF, 1'b0);
    drain();
    write_reg(oiq_pkg::CFG_USED_PORTS, 16'd0);
    send_scan(32'h0000_0000, 1'b1);
    drain();
    write_reg(oiq_pkg::CFG_USED_PORTS, 16'd63);
    write_reg(oiq_pkg::CFG_SENSE_MODE, {13'd0, 3'd7});
    send_scan(32'h0F0F_0F0F, 1'b0);
    send_scan(32'hFFFF_FFFF, 1'b1);
    drain();
  endtask

  // every power sense mode with a random release delay, short or at the maximum
  task automatic test_sense_modes();
    logic [2:0] m;
    wide_gaps = 1;
    for (int i = 0; i < 5; i++) begin
      m = 3'(i);
      drain();
      write_reg(oiq_pkg::CFG_SENSE_MODE, {13'd0, m});
      write_reg(oiq_pkg::CFG_USED_PORTS, 16'($urandom_range(8, 32)));
      write_reg(oiq_pkg::CFG_RELEASE_DELAY,
                $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 6)));
      write_reg(oiq_pkg::CFG_FIRST_ADDRESS, 16'($urandom()));
      write_reg(oiq_pkg::CFG_BUS_IDENT, 16'($urandom()));
      occ_mask = $urandom();
      for (int k = 0; k < 16; k++) begin
        if ($urandom_range(0, 7) == 0) occ_mask = $urandom();
        send_scan(occupancy_word(), $urandom_range(0, 15) != 0);
      end
    end
    drain();
  endtask

  // millisecond run until the blink phase has turned on
  task automatic test_blink();
    int k;
    wide_gaps = 0;
    write_reg(oiq_pkg::CFG_SENSE_MODE, {13'd0, oiq_pkg::SENSE_ONE});
    write_reg(oiq_pkg::CFG_USED_PORTS, 16'd32);
    write_reg(oiq_pkg::CFG_RELEASE_DELAY, 16'd2);
    k = 0;
    while (k < 300 && (k < 8 || blink_cnt < 256)) begin
      send_scan(k < 3 ? 32'h0000_0000 : 32'h0000_F0F1, 1'b1);
      k++;
    end
    drain();
  endtask

  // receiver stalls long while scans keep arriving
  task automatic test_backpressure();
    wide_gaps = 1;
    write_reg(oiq_pkg::CFG_SENSE_MODE, {13'd0, oiq_pkg::SENSE_NONE});
    write_reg(oiq_pkg::CFG_RELEASE_DELAY, 16'd0);
    hold_cycles = 200;
    for (int k = 0; k < 12; k++)
      send_scan(k[0] ? 32'hFFFF_FFFF : $urandom(), 1'b1);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = oiq_pkg::CFG_USED_PORTS;
    cfg_data = '0;
    in_valid = 1'b0;
    track_bits = '0;
    tick_elapsed = 1'b0;
    error_count = 0;
    cycle_count = 0;
    hold_cycles = 0;
    wide_gaps = 0;
    occ_mask = '1;
    cur_used = oiq_pkg::USED_PORTS_RST;
    cur_sense = oiq_pkg::SENSE_NONE;
    cur_bus = '0;
    cur_first = '0;
    cur_delay = oiq_pkg::RELEASE_DELAY_RST;
    occ_logic = '1;
    timer_on = '0;
    led_dark = '0;
    blink_cnt = 0;
    blink_on = 1'b0;
    foreach (release_cnt[p]) release_cnt[p] = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_sense_modes();
    test_backpressure();
    test_blink();
    drain();
    repeat (10) @(negedge clk);
    if (error_count == 0 && expected_events.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
